// File: src/mdpb_pkg.sv
// Shared types, widths and reset values for the masked depth pixel back-projection block.
// No dependencies; every other file of the block uses this package.
package mdpb_pkg;

    // Default module parameters
    localparam int DEF_GRID_STEP   = 2;
    localparam int DEF_COORD_BITS  = 10;

    // Fixed field widths
    localparam int COL_W      = 10;
    localparam int MASK_W     = 8;
    localparam int DEPTH_W    = 16;
    localparam int MAP_W      = 23;
    localparam int CAM_W      = 39;    // camera x/y, Q.8 depth units
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 63;

    // Output saturation limits
    localparam logic signed [MAP_W-1:0] MAP_MAX = {1'b0, {(MAP_W-1){1'b1}}};
    localparam logic signed [MAP_W-1:0] MAP_MIN = {1'b1, {(MAP_W-1){1'b0}}};

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_MIN   = 3'd0,
        CFG_DEPTH_MAX   = 3'd1,
        CFG_PRINCIPAL   = 3'd2,
        CFG_INV_FOCAL   = 3'd3,
        CFG_ROT_ROW0    = 3'd4,
        CFG_ROT_ROW1    = 3'd5,
        CFG_ROT_ROW2    = 3'd6,
        CFG_TRANSLATION = 3'd7
    } t_cfg_idx;

    // Register file contents, raw bit containers
    typedef struct packed {
        logic [15:0] depth_min;
        logic [15:0] depth_max;
        logic [31:0] principal;    // cy[31:16], cx[15:0], Q12.4
        logic [47:0] inv_focal;    // 1/fy[47:24], 1/fx[23:0], Q0.24
        logic [53:0] rot_row0;
        logic [53:0] rot_row1;
        logic [53:0] rot_row2;
        logic [62:0] translation;  // z, y, x as signed 21-bit, x lowest
    } t_cfg;

    // Register reset values
    localparam logic [15:0] RST_DEPTH_MIN   = 16'd500;
    localparam logic [15:0] RST_DEPTH_MAX   = 16'd5000;
    localparam logic [31:0] RST_PRINCIPAL   = 32'd245502936;
    localparam logic [47:0] RST_INV_FOCAL   = 48'd462883417030;
    localparam logic [53:0] RST_ROT_ROW0    = 54'd65536;
    localparam logic [53:0] RST_ROT_ROW1    = 54'd17179869184;
    localparam logic [53:0] RST_ROT_ROW2    = 54'd4503599627370496;
    localparam logic [62:0] RST_TRANSLATION = 63'd0;

    // Camera-frame point handed from back-projection to the transform
    typedef struct packed {
        logic                    ok;
        logic signed [CAM_W-1:0] xc;
        logic signed [CAM_W-1:0] yc;
        logic [DEPTH_W-1:0]      depth;
    } t_cam;

endpackage

// File: src/mdpb_ifaces.sv
// Valid/ready channel interfaces of the back-projection block: pixel in, point out,
// register writes, and the internal camera-point channel. Depends on mdpb_pkg.

interface mdpb_pix_if;
    logic                            valid;
    logic                            ready;
    logic [mdpb_pkg::COL_W-1:0]      col;
    logic [mdpb_pkg::COL_W-1:0]      row;
    logic [mdpb_pkg::MASK_W-1:0]     mask_blue;
    logic [mdpb_pkg::MASK_W-1:0]     mask_green;
    logic [mdpb_pkg::MASK_W-1:0]     mask_red;
    logic [mdpb_pkg::DEPTH_W-1:0]    depth_raw;

    modport source (output valid, col, row, mask_blue, mask_green, mask_red, depth_raw,
                    input ready);
    modport sink   (input valid, col, row, mask_blue, mask_green, mask_red, depth_raw,
                    output ready);
endinterface

interface mdpb_pt_if;
    logic                                valid;
    logic                                ready;
    logic                                point_valid;
    logic signed [mdpb_pkg::MAP_W-1:0]   map_x;
    logic signed [mdpb_pkg::MAP_W-1:0]   map_y;
    logic signed [mdpb_pkg::MAP_W-1:0]   map_z;

    modport source (output valid, point_valid, map_x, map_y, map_z, input ready);
    modport sink   (input valid, point_valid, map_x, map_y, map_z, output ready);
endinterface

interface mdpb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mdpb_pkg::CFG_IDX_W-1:0]     index;
    logic [mdpb_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface mdpb_cam_if;
    logic           valid;
    logic           ready;
    mdpb_pkg::t_cam cam;

    modport source (output valid, cam, input ready);
    modport sink   (input valid, cam, output ready);
endinterface

// File: src/mdpb_cfg.sv
// Configuration register file: decodes register-write transactions into t_cfg.
// Depends on mdpb_pkg and mdpb_cfg_if.
module mdpb_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mdpb_cfg_if.sink        i_cfg,
    output mdpb_pkg::t_cfg  o_cfg
);

    mdpb_pkg::t_cfg r_cfg;

    // Writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_min   <= mdpb_pkg::RST_DEPTH_MIN;
            r_cfg.depth_max   <= mdpb_pkg::RST_DEPTH_MAX;
            r_cfg.principal   <= mdpb_pkg::RST_PRINCIPAL;
            r_cfg.inv_focal   <= mdpb_pkg::RST_INV_FOCAL;
            r_cfg.rot_row0    <= mdpb_pkg::RST_ROT_ROW0;
            r_cfg.rot_row1    <= mdpb_pkg::RST_ROT_ROW1;
            r_cfg.rot_row2    <= mdpb_pkg::RST_ROT_ROW2;
            r_cfg.translation <= mdpb_pkg::RST_TRANSLATION;
        end else if (i_cfg.valid) begin
            unique case (mdpb_pkg::t_cfg_idx'(i_cfg.index))
                mdpb_pkg::CFG_DEPTH_MIN:   r_cfg.depth_min   <= i_cfg.data[15:0];
                mdpb_pkg::CFG_DEPTH_MAX:   r_cfg.depth_max   <= i_cfg.data[15:0];
                mdpb_pkg::CFG_PRINCIPAL:   r_cfg.principal   <= i_cfg.data[31:0];
                mdpb_pkg::CFG_INV_FOCAL:   r_cfg.inv_focal   <= i_cfg.data[47:0];
                mdpb_pkg::CFG_ROT_ROW0:    r_cfg.rot_row0    <= i_cfg.data[53:0];
                mdpb_pkg::CFG_ROT_ROW1:    r_cfg.rot_row1    <= i_cfg.data[53:0];
                mdpb_pkg::CFG_ROT_ROW2:    r_cfg.rot_row2    <= i_cfg.data[53:0];
                mdpb_pkg::CFG_TRANSLATION: r_cfg.translation <= i_cfg.data[62:0];
                default: ;
            endcase
        end
    end

endmodule

// File: src/mdpb_cam.sv
// Back-projection pipeline: pixel screening and pinhole model to camera frame, 4 stages.
// Depends on mdpb_pkg, mdpb_pix_if and mdpb_cam_if.
module mdpb_cam #(
    parameter int GRID_STEP  = mdpb_pkg::DEF_GRID_STEP,
    parameter int COORD_BITS = mdpb_pkg::DEF_COORD_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mdpb_pkg::t_cfg  i_cfg,
    mdpb_pix_if.sink        i_pix,
    mdpb_cam_if.source      o_cam
);

    localparam int NS    = 4;
    localparam int DW    = mdpb_pkg::DEPTH_W;
    localparam int CW    = mdpb_pkg::COL_W;
    localparam int DX_W  = 17;
    localparam int PD_W  = 34;
    localparam int PX_W  = 59;
    localparam int CAM_W = mdpb_pkg::CAM_W;
    // Divisibility by the grid step through a reciprocal multiply
    localparam int DIV_SH = 24;
    localparam int DQ_W   = CW + 1;
    localparam int DP_W   = CW + DIV_SH + 1;
    localparam logic [DIV_SH:0] DIV_M =
        (DIV_SH+1)'(((64'd1 << DIV_SH) + 64'(GRID_STEP) - 64'd1) / 64'(GRID_STEP));

    logic [NS-1:0] r_vld;
    logic [NS:0]   ld;

    // Stage registers
    logic                    r_s1_ok, r_s2_ok, r_s3_ok, r_s4_ok;
    logic [DW-1:0]           r_s1_d, r_s2_d, r_s3_d, r_s4_d;
    logic signed [DX_W-1:0]  r_s1_dx, r_s1_dy;
    logic signed [PD_W-1:0]  r_s2_pdx, r_s2_pdy;
    logic signed [PX_W-1:0]  r_s3_px, r_s3_py;
    logic signed [CAM_W-1:0] r_s4_xc, r_s4_yc;

    // Stage 1 next values
    logic [COORD_BITS-1:0]   u, v;
    logic [DP_W-1:0]         col_prod, row_prod;
    logic [DQ_W-1:0]         col_q, row_q;
    logic                    col_ok, row_ok, n_s1_ok;
    logic signed [DX_W-1:0]  n_s1_dx, n_s1_dy;
    // Later stage next values
    logic signed [PD_W-1:0]  n_s2_pdx, n_s2_pdy;
    logic signed [PX_W-1:0]  n_s3_px, n_s3_py;
    logic signed [CAM_W-1:0] n_s4_xc, n_s4_yc;

    // Load chain: a stage takes new data when empty or when its successor moves
    always_comb begin
        ld[NS] = o_cam.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign i_pix.ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: screening and offsets from the principal point
    always_comb begin
        col_prod = DP_W'(i_pix.col) * DP_W'(DIV_M);
        row_prod = DP_W'(i_pix.row) * DP_W'(DIV_M);
        col_q    = col_prod[DP_W-1:DIV_SH];
        row_q    = row_prod[DP_W-1:DIV_SH];
        col_ok   = (16'(col_q) * 16'(GRID_STEP)) == 16'(i_pix.col);
        row_ok   = (16'(row_q) * 16'(GRID_STEP)) == 16'(i_pix.row);
        n_s1_ok  = col_ok && row_ok
                   && (|{i_pix.mask_blue, i_pix.mask_green, i_pix.mask_red})
                   && (i_pix.depth_raw >= i_cfg.depth_min)
                   && (i_pix.depth_raw <= i_cfg.depth_max);
        u        = COORD_BITS'(i_pix.col);
        v        = COORD_BITS'(i_pix.row);
        n_s1_dx  = DX_W'($signed({1'b0, u, 4'b0000}))
                   - DX_W'($signed({1'b0, i_cfg.principal[15:0]}));
        n_s1_dy  = DX_W'($signed({1'b0, v, 4'b0000}))
                   - DX_W'($signed({1'b0, i_cfg.principal[31:16]}));
    end

    // Stage 2: offset times depth
    assign n_s2_pdx = PD_W'(r_s1_dx) * PD_W'($signed({1'b0, r_s1_d}));
    assign n_s2_pdy = PD_W'(r_s1_dy) * PD_W'($signed({1'b0, r_s1_d}));

    // Stage 3: times inverse focal length
    assign n_s3_px = PX_W'(r_s2_pdx) * PX_W'($signed({1'b0, i_cfg.inv_focal[23:0]}));
    assign n_s3_py = PX_W'(r_s2_pdy) * PX_W'($signed({1'b0, i_cfg.inv_focal[47:24]}));

    // Stage 4: drop 20 fraction bits, rounding toward zero
    assign n_s4_xc = CAM_W'((r_s3_px + (r_s3_px[PX_W-1] ? PX_W'(20'hFFFFF) : PX_W'(0)))
                            >>> 20);
    assign n_s4_yc = CAM_W'((r_s3_py + (r_s3_py[PX_W-1] ? PX_W'(20'hFFFFF) : PX_W'(0)))
                            >>> 20);

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s1_ok <= n_s1_ok;
            r_s1_d  <= i_pix.depth_raw;
            r_s1_dx <= n_s1_dx;
            r_s1_dy <= n_s1_dy;
        end
        if (ld[1]) begin
            r_s2_ok  <= r_s1_ok;
            r_s2_d   <= r_s1_d;
            r_s2_pdx <= n_s2_pdx;
            r_s2_pdy <= n_s2_pdy;
        end
        if (ld[2]) begin
            r_s3_ok <= r_s2_ok;
            r_s3_d  <= r_s2_d;
            r_s3_px <= n_s3_px;
            r_s3_py <= n_s3_py;
        end
        if (ld[3]) begin
            r_s4_ok <= r_s3_ok;
            r_s4_d  <= r_s3_d;
            r_s4_xc <= n_s4_xc;
            r_s4_yc <= n_s4_yc;
        end
    end

    assign o_cam.valid     = r_vld[NS-1];
    assign o_cam.cam.ok    = r_s4_ok;
    assign o_cam.cam.xc    = r_s4_xc;
    assign o_cam.cam.yc    = r_s4_yc;
    assign o_cam.cam.depth = r_s4_d;

endmodule

// File: src/mdpb_xform.sv
// Rigid transform pipeline: rotation, translation, truncation and saturation, 4 stages.
// Depends on mdpb_pkg, mdpb_cam_if and mdpb_pt_if.
module mdpb_xform (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mdpb_pkg::t_cfg  i_cfg,
    mdpb_cam_if.sink        i_cam,
    mdpb_pt_if.source       o_pt
);

    localparam int NS    = 4;
    localparam int CAM_W = mdpb_pkg::CAM_W;
    localparam int MAP_W = mdpb_pkg::MAP_W;
    localparam int P_W   = 57;
    localparam int S_W   = 60;
    localparam int Q_W   = S_W - 24;

    logic [NS-1:0] r_vld;
    logic [NS:0]   ld;

    logic                    r_x1_ok, r_x2_ok, r_x3_ok;
    logic signed [P_W-1:0]   r_x1_p [3][3];
    logic signed [S_W-1:0]   r_x2_a [3];
    logic signed [S_W-1:0]   r_x2_b [3];
    logic signed [S_W-1:0]   r_x3_s [3];
    logic                    r_out_pv;
    logic signed [MAP_W-1:0] r_out_map [3];

    logic signed [P_W-1:0]   n_x1_p [3][3];
    logic signed [S_W-1:0]   n_x2_a [3];
    logic signed [S_W-1:0]   n_x2_b [3];
    logic signed [MAP_W-1:0] n_out_map [3];
    logic signed [Q_W-1:0]   q [3];
    logic [53:0]             rot [3];
    logic signed [P_W-1:0]   cam_k [3];

    // Load chain, same scheme as the back-projection pipeline
    always_comb begin
        ld[NS] = o_pt.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign i_cam.ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_cam.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: nine rotation products; the z term is depth, scaled by 2^8 later
    always_comb begin
        rot[0]   = i_cfg.rot_row0;
        rot[1]   = i_cfg.rot_row1;
        rot[2]   = i_cfg.rot_row2;
        cam_k[0] = P_W'(i_cam.cam.xc);
        cam_k[1] = P_W'(i_cam.cam.yc);
        cam_k[2] = P_W'($signed({1'b0, i_cam.cam.depth}));
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_x1_p[i][k] = P_W'($signed(rot[i][18*k +: 18])) * cam_k[k];
            end
        end
    end

    // Stage 2: partial sums, translation placed at Q.24
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_x2_a[i] = S_W'(r_x1_p[i][0]) + S_W'(r_x1_p[i][1]);
            n_x2_b[i] = (S_W'(r_x1_p[i][2]) <<< 8)
                        + (S_W'($signed(i_cfg.translation[21*i +: 21])) <<< 24);
        end
    end

    // Stage 4: divide by 2^24 toward zero, saturate, zero rejected pixels
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            q[i] = Q_W'(r_x3_s[i] >>> 24)
                   + Q_W'(r_x3_s[i][S_W-1] && (|r_x3_s[i][23:0]));
            if (!r_x3_ok) begin
                n_out_map[i] = '0;
            end else if (q[i] > Q_W'(mdpb_pkg::MAP_MAX)) begin
                n_out_map[i] = mdpb_pkg::MAP_MAX;
            end else if (q[i] < Q_W'(mdpb_pkg::MAP_MIN)) begin
                n_out_map[i] = mdpb_pkg::MAP_MIN;
            end else begin
                n_out_map[i] = MAP_W'(q[i]);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_x1_ok <= i_cam.cam.ok;
            r_x1_p  <= n_x1_p;
        end
        if (ld[1]) begin
            r_x2_ok <= r_x1_ok;
            r_x2_a  <= n_x2_a;
            r_x2_b  <= n_x2_b;
        end
        if (ld[2]) begin
            r_x3_ok <= r_x2_ok;
            for (int i = 0; i < 3; i++) begin
                r_x3_s[i] <= r_x2_a[i] + r_x2_b[i];
            end
        end
        if (ld[3]) begin
            r_out_pv  <= r_x3_ok;
            r_out_map <= n_out_map;
        end
    end

    assign o_pt.valid       = r_vld[NS-1];
    assign o_pt.point_valid = r_out_pv;
    assign o_pt.map_x       = r_out_map[0];
    assign o_pt.map_y       = r_out_map[1];
    assign o_pt.map_z       = r_out_map[2];

endmodule

// File: src/masked_depth_pixel_backprojection.sv
// Top level of the masked depth pixel back-projection block.
// Depends on mdpb_pkg, mdpb_ifaces, mdpb_cfg, mdpb_cam and mdpb_xform.
//
//   channel   direction  transaction
//   i_pix     in         one pixel: col, row, mask_blue/green/red, depth_raw
//   o_pt      out        one point: point_valid, map_x, map_y, map_z
//   i_cfg     in         one register write: index, data
//
// One pixel per clock sustained while o_pt is ready; the path has 4 back-projection stages
// and 4 transform stages, the last stage being the output register.
// Synchronous active-low reset clears all stage valid bits and loads register defaults.
// Each stage holds while its successor is full and stalled; empty stages keep
// filling, so i_pix.ready drops only when all 8 stages hold data and o_pt stalls.
module masked_depth_pixel_backprojection #(
    parameter int GRID_STEP  = mdpb_pkg::DEF_GRID_STEP,
    parameter int COORD_BITS = mdpb_pkg::DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mdpb_pix_if.sink    i_pix,
    mdpb_cfg_if.sink    i_cfg,
    mdpb_pt_if.source   o_pt
);

    mdpb_pkg::t_cfg cfg;
    mdpb_cam_if     cam_ch ();

    // Register file
    mdpb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Pixel to camera frame
    mdpb_cam #(
        .GRID_STEP  (GRID_STEP),
        .COORD_BITS (COORD_BITS)
    ) u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_cam   (cam_ch.source)
    );

    // Camera frame to map frame
    mdpb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cam   (cam_ch.sink),
        .o_pt    (o_pt)
    );

endmodule

// File: bench/masked_depth_pixel_backprojection_tb.sv
// Self-checking bench for masked_depth_pixel_backprojection: random and directed pixels,
// a fixed-point back-projection predictor, and register rewrites between drained phases.
// Depends on mdpb_pkg, mdpb_ifaces and the block under test.
module masked_depth_pixel_backprojection_tb;

    localparam int SKIP        = mdpb_pkg::DEF_GRID_STEP;
    localparam int COORD       = mdpb_pkg::DEF_COORD_BITS;
    localparam longint COORD_MAX  = 4194303;
    localparam longint COORD_MIN  = -4194304;
    localparam int HOLD_CYCLES = 80;
    localparam longint TIMEOUT = 64'd16_000_000;

    typedef struct packed {
        logic [mdpb_pkg::COL_W-1:0]   col;
        logic [mdpb_pkg::COL_W-1:0]   row;
        logic [mdpb_pkg::MASK_W-1:0]  blue;
        logic [mdpb_pkg::MASK_W-1:0]  green;
        logic [mdpb_pkg::MASK_W-1:0]  red;
        logic [mdpb_pkg::DEPTH_W-1:0] depth;
    } t_pixel;

    typedef struct packed {
        logic                              hit;
        logic signed [mdpb_pkg::MAP_W-1:0] x;
        logic signed [mdpb_pkg::MAP_W-1:0] y;
        logic signed [mdpb_pkg::MAP_W-1:0] z;
    } t_map_point;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mdpb_pix_if pix_if();
    mdpb_cfg_if cfg_if();
    mdpb_pt_if  pt_if();

    masked_depth_pixel_backprojection #(
        .GRID_STEP  (SKIP),
        .COORD_BITS (COORD)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_pt    (pt_if)
    );

    // Shadow copy of the calibration registers
    mdpb_pkg::t_cfg calib;
    t_pixel     pixel_queue [$];
    t_map_point expected_points [$];
    t_pixel     on_wire;
    int         mismatches = 0;
    int         points_checked = 0;
    int         send_gap = 0;
    int         send_burst = 0;
    int         stall_left = 0;
    int         stall_burst = 0;
    logic       long_hold = 1'b0;

    always begin
        #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("ERROR at %0t: %s", $time, what);
        mismatches++;
    endtask

    // Divide by 2^s, rounding toward zero
    function automatic longint trunc_shr(input longint v, input int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    // Pinhole back-projection plus rigid transform, Q.8 camera point, Q.24 sums
    function automatic t_map_point backproject(input t_pixel p);
        t_map_point                        pt;
        longint                            cam [3];
        longint                            dd, dx, dy, acc, m;
        logic [53:0]                       rows [3];
        logic signed [mdpb_pkg::MAP_W-1:0] coord [3];
        pt = '0;
        if ((int'(p.col) % SKIP) != 0 || (int'(p.row) % SKIP) != 0)
            return pt;
        if ({p.blue, p.green, p.red} == '0)
            return pt;
        if (p.depth < calib.depth_min || p.depth > calib.depth_max)
            return pt;
        dd = longint'(p.depth);
        dx = (longint'(p.col) & ((longint'(1) <<< COORD) - 1)) * 16
             - longint'(calib.principal[15:0]);
        dy = (longint'(p.row) & ((longint'(1) <<< COORD) - 1)) * 16
             - longint'(calib.principal[31:16]);
        cam[0] = trunc_shr(dx * dd * longint'(calib.inv_focal[23:0]), 20);
        cam[1] = trunc_shr(dy * dd * longint'(calib.inv_focal[47:24]), 20);
        cam[2] = dd * 256;
        rows[0] = calib.rot_row0;
        rows[1] = calib.rot_row1;
        rows[2] = calib.rot_row2;
        for (int i = 0; i < 3; i++) begin
            acc = longint'($signed(calib.translation[21*i +: 21])) * (longint'(1) <<< 24);
            for (int k = 0; k < 3; k++)
                acc += longint'($signed(rows[i][18*k +: 18])) * cam[k];
            m = trunc_shr(acc, 24);
            if (m > COORD_MAX) m = COORD_MAX;
            if (m < COORD_MIN) m = COORD_MIN;
            coord[i] = m[mdpb_pkg::MAP_W-1:0];
        end
        pt.hit = 1'b1;
        pt.x = coord[0];
        pt.y = coord[1];
        pt.z = coord[2];
        return pt;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int srand(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [53:0] pack_row(input int a, input int b, input int c);
        return {c[17:0], b[17:0], a[17:0]};
    endfunction

    function automatic logic [62:0] pack_trans(input int x, input int y, input int z);
        return {z[20:0], y[20:0], x[20:0]};
    endfunction

    // Mostly pixels that pass the mask, grid and depth gates; the rest noise or one gate broken
    function automatic t_pixel rand_pixel();
        t_pixel px;
        int     kind;
        int     r;
        kind = $urandom_range(0, 99);
        px.col = 10'(($urandom_range(0, 1023) / SKIP) * SKIP);
        px.row = 10'(($urandom_range(0, 1023) / SKIP) * SKIP);
        px.blue = '0;
        px.green = '0;
        px.red = '0;
        case ($urandom_range(0, 3))
            0: px.blue = 8'($urandom_range(1, 255));
            1: px.green = 8'($urandom_range(1, 255));
            2: px.red = 8'($urandom_range(1, 255));
            default: begin
                px.blue = 8'($urandom);
                px.green = 8'($urandom);
                px.red = 8'($urandom_range(1, 255));
            end
        endcase
        r = $urandom_range(0, 9);
        if (r == 0)
            px.depth = calib.depth_min;
        else if (r == 1)
            px.depth = calib.depth_max;
        else
            px.depth = 16'($urandom_range(calib.depth_min, calib.depth_max));
        if (kind < 20) begin
            px = 60'({$urandom, $urandom});
        end else if (kind < 30) begin
            case ($urandom_range(0, 3))
                0: px.col = px.col + 1'b1;
                1: px.row = px.row + 1'b1;
                2: {px.blue, px.green, px.red} = '0;
                default: begin
                    if (calib.depth_max != 16'hFFFF)
                        px.depth = calib.depth_max + 1'b1;
                    else if (calib.depth_min != 16'h0000)
                        px.depth = calib.depth_min - 1'b1;
                end
            endcase
        end
        return px;
    endfunction

    task automatic queue_pixel(input int c, input int r, input int b, input int g,
                               input int rd, input int d);
        t_pixel px;
        px.col = 10'(c);
        px.row = 10'(r);
        px.blue = 8'(b);
        px.green = 8'(g);
        px.red = 8'(rd);
        px.depth = 16'(d);
        pixel_queue.insert(pixel_queue.size(), px);
    endtask

    task automatic queue_random(input int n);
        repeat (n) pixel_queue.insert(pixel_queue.size(), rand_pixel());
    endtask

    // Block until the sender is empty and every expected point has come back;
    // sampled away from the rising edge so the clocked processes have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || pix_if.valid || expected_points.size() != 0);
    endtask

    // One register write transaction; the shadow copy follows it
    task automatic write_reg(input mdpb_pkg::t_cfg_idx idx, input logic [62:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            mdpb_pkg::CFG_DEPTH_MIN:   calib.depth_min = value[15:0];
            mdpb_pkg::CFG_DEPTH_MAX:   calib.depth_max = value[15:0];
            mdpb_pkg::CFG_PRINCIPAL:   calib.principal = value[31:0];
            mdpb_pkg::CFG_INV_FOCAL:   calib.inv_focal = value[47:0];
            mdpb_pkg::CFG_ROT_ROW0:    calib.rot_row0 = value[53:0];
            mdpb_pkg::CFG_ROT_ROW1:    calib.rot_row1 = value[53:0];
            mdpb_pkg::CFG_ROT_ROW2:    calib.rot_row2 = value[53:0];
            mdpb_pkg::CFG_TRANSLATION: calib.translation = value[62:0];
        endcase
    endtask

    // Write all registers; sometimes with junk above each register's width
    task automatic load_calib(input logic [15:0] dmin, input logic [15:0] dmax,
                              input logic [31:0] pp, input logic [47:0] focal,
                              input logic [53:0] r0, input logic [53:0] r1,
                              input logic [53:0] r2, input logic [62:0] tr);
        logic [63:0] junk;
        junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        write_reg(mdpb_pkg::CFG_DEPTH_MIN, {junk[62:16], dmin});
        write_reg(mdpb_pkg::CFG_DEPTH_MAX, {junk[61:15], dmax});
        write_reg(mdpb_pkg::CFG_PRINCIPAL, {junk[62:32], pp});
        write_reg(mdpb_pkg::CFG_INV_FOCAL, {junk[62:48], focal});
        write_reg(mdpb_pkg::CFG_ROT_ROW0, {junk[62:54], r0});
        write_reg(mdpb_pkg::CFG_ROT_ROW1, {junk[60:52], r1});
        write_reg(mdpb_pkg::CFG_ROT_ROW2, {junk[58:50], r2});
        write_reg(mdpb_pkg::CFG_TRANSLATION, tr);
    endtask

    // Pixel sender: predicts each accepted transaction, then idles or offers the next one
    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pix_if.valid && pix_if.ready)
                expected_points.insert(expected_points.size(), backproject(on_wire));
            if (!pix_if.valid || pix_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pix_if.valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    on_wire = pixel_queue.pop_front();
                    pix_if.valid <= 1'b1;
                    pix_if.col <= on_wire.col;
                    pix_if.row <= on_wire.row;
                    pix_if.mask_blue <= on_wire.blue;
                    pix_if.mask_green <= on_wire.green;
                    pix_if.mask_red <= on_wire.red;
                    pix_if.depth_raw <= on_wire.depth;
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else begin
                        if ($urandom_range(0, 49) == 0)
                            send_burst = $urandom_range(20, 60);
                        send_gap = idle_len();
                    end
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Point receiver: checks each transaction against the oldest prediction
    always @(posedge i_clk) begin : point_monitor
        t_map_point got;
        t_map_point want;
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                got.hit = pt_if.point_valid;
                got.x = pt_if.map_x;
                got.y = pt_if.map_y;
                got.z = pt_if.map_z;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("point %0d arrived with no pixel pending",
                                              points_checked));
                end else begin
                    want = expected_points.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("point %0d point_valid %0b, want %0b",
                                                  points_checked, got.hit, want.hit));
                    if (got.x !== want.x)
                        report_mismatch($sformatf("point %0d map_x %0d, want %0d",
                                                  points_checked, got.x, want.x));
                    if (got.y !== want.y)
                        report_mismatch($sformatf("point %0d map_y %0d, want %0d",
                                                  points_checked, got.y, want.y));
                    if (got.z !== want.z)
                        report_mismatch($sformatf("point %0d map_z %0d, want %0d",
                                                  points_checked, got.z, want.z));
                end
                points_checked++;
            end
            if (long_hold) begin
                pt_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pt_if.ready <= 1'b0;
            end else begin
                pt_if.ready <= 1'b1;
                if (stall_burst > 0)
                    stall_burst--;
                else if ($urandom_range(0, 49) == 0)
                    stall_burst = $urandom_range(20, 60);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Long receiver back-pressure so the pipeline fills and stalls the pixel input
    initial begin : receiver_hold_off
        wait (points_checked >= 150);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
        wait (points_checked >= 1000);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : watchdog
        #TIMEOUT;
        $display("masked_depth_pixel_backprojection_tb failed");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] lo;
        i_rst_n = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.col = '0;
        pix_if.row = '0;
        pix_if.mask_blue = '0;
        pix_if.mask_green = '0;
        pix_if.mask_red = '0;
        pix_if.depth_raw = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = mdpb_pkg::CFG_DEPTH_MIN;
        cfg_if.data = '0;
        pt_if.ready = 1'b0;
        // power-on register values
        calib.depth_min = 16'd500;
        calib.depth_max = 16'd5000;
        calib.principal = 32'd245502936;
        calib.inv_focal = 48'd462883417030;
        calib.rot_row0 = 54'd65536;
        calib.rot_row1 = 54'd17179869184;
        calib.rot_row2 = 54'd4503599627370496;
        calib.translation = 63'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: depth limits, grid, mask bytes and coordinate extremes at reset values
        queue_pixel(0, 0, 1, 0, 0, 500);
        queue_pixel(1022, 1022, 0, 1, 0, 5000);
        queue_pixel(1023, 0, 255, 255, 255, 1000);
        queue_pixel(0, 1023, 255, 0, 0, 1000);
        queue_pixel(320, 240, 0, 0, 0, 1000);
        queue_pixel(320, 240, 0, 0, 128, 499);
        queue_pixel(320, 240, 0, 128, 0, 5001);
        queue_pixel(320, 240, 255, 255, 255, 0);
        queue_pixel(320, 240, 1, 1, 1, 65535);
        queue_pixel(318, 234, 255, 0, 0, 2000);
        queue_pixel(0, 1022, 0, 0, 1, 5000);
        queue_pixel(1022, 0, 0, 255, 0, 500);
        queue_pixel(2, 2, 0, 0, 255, 1234);
        queue_pixel(1021, 1021, 0, 0, 0, 65535);
        queue_pixel(640, 480, 170, 85, 0, 4321);
        queue_pixel(512, 512, 0, 85, 170, 3000);
        queue_random(250);
        wait_idle();

        // Full depth range, largest gains, extreme rotation entries: saturates
        load_calib(16'd0, 16'hFFFF, 32'd0, 48'hFFFF_FFFF_FFFF,
                   pack_row(131071, -131072, 131071),
                   pack_row(-131072, -131072, -131072),
                   pack_row(131071, 131071, 131071),
                   pack_trans(1048575, -1048576, 1048575));
        queue_random(200);
        wait_idle();

        // Single accepted depth at the top, largest principal point, zero gains
        load_calib(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 48'd0,
                   pack_row(0, 0, -131072),
                   pack_row(65536, 0, 0),
                   pack_row(0, -65536, 131071),
                   pack_trans(-1048576, 1048575, -1048576));
        queue_random(100);
        wait_idle();

        // Only zero depth accepted: the point is the camera position
        load_calib(16'd0, 16'd0, 32'd245502936, 48'd462883417030,
                   pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536),
                   pack_trans(123456, -654321, 1000));
        queue_random(40);
        wait_idle();

        // Inverted limits: nothing accepted
        load_calib(16'd40000, 16'd39999, 32'd245502936, 48'd462883417030,
                   pack_row(65536, 0, 0), pack_row(0, 65536, 0), pack_row(0, 0, 65536),
                   63'd0);
        queue_random(60);
        wait_idle();

        // Random poses and intrinsics
        for (int n = 0; n < 4; n++) begin
            lo = 16'($urandom_range(0, 3000));
            load_calib(lo, 16'($urandom_range(lo, 65535)),
                       {16'($urandom_range(0, 16383)), 16'($urandom_range(0, 16383))},
                       ($urandom_range(0, 3) == 0) ? 48'({$urandom, $urandom})
                           : {24'($urandom_range(5000, 120000)),
                              24'($urandom_range(5000, 120000))},
                       pack_row(srand(65536), srand(65536), srand(65536)),
                       pack_row(srand(65536), srand(65536), srand(65536)),
                       pack_row(srand(65536), srand(65536), srand(65536)),
                       pack_trans(srand(1048576), srand(1048576), srand(1048576)));
            queue_random(160);
            wait_idle();
        end

        // Typical camera, sender pauses until drained halfway through
        load_calib(16'd300, 16'd8000, 32'd245502936, 48'd462883417030,
                   pack_row(0, 0, 65536), pack_row(-65536, 0, 0), pack_row(0, -65536, 0),
                   pack_trans(2500, -1200, 800));
        queue_random(80);
        wait_idle();
        queue_random(80);
        wait_idle();

        repeat (16) @(posedge i_clk);
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
        if (mismatches == 0)
            $display("masked_depth_pixel_backprojection_tb passed");
        else
            $display("masked_depth_pixel_backprojection_tb failed");
        $finish;
    end

endmodule
